/* design/assert_macros.svh */
// Assertion macros shared by the formatter modules.
// Users must provide i_clk and i_rst_n; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define ITF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define ITF_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define ITF_ASSERT(lbl, prop, msg)
`define ITF_NEVER(lbl, expr, msg)
`endif
`endif

/* design/itf_pkg.sv */
// Shared types, codes and character tables for the integer text formatter.
// No dependencies.
package itf_pkg;

    localparam int MAX_WIDTH_DEF = 64;
    localparam int BODY_DIGITS   = 20;
    localparam int DIGIT_BITS    = 4 * BODY_DIGITS;
    localparam int NDIG_W        = 5;
    localparam int CONV_STEPS    = 64;
    localparam int CNT_W         = 6;

    localparam logic [2:0] KIND_SDEC = 3'd0;
    localparam logic [2:0] KIND_UDEC = 3'd1;
    localparam logic [2:0] KIND_HEXL = 3'd2;
    localparam logic [2:0] KIND_HEXU = 3'd3;
    localparam logic [2:0] KIND_CHAR = 3'd4;
    localparam logic [2:0] KIND_PCT  = 3'd5;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;

    localparam logic [7:0] LOWER_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };
    localparam logic [7:0] UPPER_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CONV,
        ST_NORM,
        ST_PREP,
        ST_LEAD,
        ST_PAD_L,
        ST_SIGN,
        ST_DIGIT,
        ST_CHAR,
        ST_PAD_R
    } t_state;

    typedef enum logic [2:0] {
        SEL_PAD,
        SEL_SPACE,
        SEL_MINUS,
        SEL_DIGIT,
        SEL_CHAR
    } t_out_sel;

    typedef struct packed {
        logic     load;
        logic     conv;
        logic     norm;
        logic     prep;
        logic     pad_dec;
        logic     digit_shift;
        logic     emit;
        t_out_sel sel;
        logic     last;
    } t_cmd;

    typedef struct packed {
        logic kind_dec;
        logic kind_hex;
        logic kind_chr;
        logic kind_bad;
        logic conv_done;
        logic norm_done;
        logic pad_zero;
        logic pad_one;
        logic ndig_one;
        logic neg;
        logic left;
    } t_sts;

    function automatic logic [7:0] itf_digit_char(input logic [3:0] nib, input logic upper);
        return upper ? UPPER_DIGITS[nib] : LOWER_DIGITS[nib];
    endfunction

endpackage

/* design/itf_ctrl.sv */
// Sequencer for the formatter: conversion, normalization and emission phases.
// Depends on itf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module itf_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  itf_pkg::t_sts i_sts,
    output itf_pkg::t_cmd o_cmd
);
    import itf_pkg::*;

    t_state r_state;
    t_state n_state;
    t_state body_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign body_state = i_sts.neg ? ST_SIGN : (i_sts.kind_chr ? ST_CHAR : ST_DIGIT);
    assign busy = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.sel = SEL_PAD;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_sts.kind_dec) n_state = ST_CONV;
                else if (i_sts.kind_hex) n_state = ST_NORM;
                else if (i_sts.kind_chr) n_state = ST_PREP;
                else n_state = ST_IDLE;
            end
            ST_CONV: begin
                o_cmd.conv = 1'b1;
                if (i_sts.conv_done) n_state = ST_NORM;
            end
            ST_NORM: begin
                if (i_sts.norm_done) n_state = ST_PREP;
                else o_cmd.norm = 1'b1;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = ST_LEAD;
            end
            ST_LEAD: begin
                if (!i_sts.left && !i_sts.pad_zero) n_state = ST_PAD_L;
                else n_state = body_state;
            end
            ST_PAD_L: begin
                o_cmd.emit    = 1'b1;
                o_cmd.sel     = SEL_PAD;
                o_cmd.pad_dec = 1'b1;
                if (i_sts.pad_one) n_state = body_state;
            end
            ST_SIGN: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = SEL_MINUS;
                n_state    = ST_DIGIT;
            end
            ST_DIGIT: begin
                o_cmd.emit        = 1'b1;
                o_cmd.sel         = SEL_DIGIT;
                o_cmd.digit_shift = 1'b1;
                if (i_sts.ndig_one) begin
                    if (i_sts.pad_zero) begin
                        o_cmd.last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_state = ST_PAD_R;
                    end
                end
            end
            ST_CHAR: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = SEL_CHAR;
                if (i_sts.pad_zero) begin
                    o_cmd.last = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    n_state = ST_PAD_R;
                end
            end
            ST_PAD_R: begin
                o_cmd.emit    = 1'b1;
                o_cmd.sel     = SEL_SPACE;
                o_cmd.pad_dec = 1'b1;
                if (i_sts.pad_one) begin
                    o_cmd.last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // trailing pad only exists for left-aligned requests
    `ITF_ASSERT(a_tail_pad_left, (r_state == ST_DIGIT && i_sts.ndig_one && !i_sts.pad_zero) |-> i_sts.left, "trailing pad without left align")
    `ITF_ASSERT(a_bad_kind_drop, (r_state == ST_DISPATCH && i_sts.kind_bad) |=> (r_state == ST_IDLE), "unknown kind not dropped")
    `ITF_NEVER(a_load_when_busy, o_cmd.load && busy, "load issued while busy")

endmodule

/* design/itf_dp.sv */
// Formatter datapath: request capture, shift-add-3 decimal conversion,
// leading-zero strip, pad counter and registered character output. Uses itf_pkg.
`include "assert_macros.svh"
module itf_dp #(
    parameter int MAX_WIDTH = itf_pkg::MAX_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [2:0]    i_req_type,
    input  logic [63:0]   i_value,
    input  logic          i_wide,
    input  logic [6:0]    i_field_width,
    input  logic          i_zero_pad,
    input  logic          i_left_align,
    input  itf_pkg::t_cmd i_cmd,
    output itf_pkg::t_sts o_sts,
    output logic [7:0]    o_out_char,
    output logic          o_last,
    output logic          o_strobe
);
    import itf_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [2:0]            r_kind;
    logic                  r_upper;
    logic                  r_neg;
    logic                  r_left;
    logic                  r_zero;
    logic [WW-1:0]         r_width;
    logic [63:0]           r_bin;
    logic [DIGIT_BITS-1:0] r_digits;
    logic [NDIG_W-1:0]     r_ndig;
    logic [CNT_W-1:0]      r_cnt;
    logic [WW-1:0]         r_pad;
    logic [7:0]            r_char;
    logic [7:0]            r_out_char;
    logic                  r_last;
    logic                  r_strobe;

    logic                  ld_neg;
    logic [63:0]           ld_mag;
    logic [31:0]           ld_lo;
    logic                  ld_chr;
    logic [WW-1:0]         ld_width;
    logic [DIGIT_BITS-1:0] adj;
    logic [NDIG_W-1:0]     body_len;
    logic [7:0]            n_out_char;

    // magnitude and sign of the incoming value
    always_comb begin
        ld_lo  = i_value[31:0];
        ld_neg = 1'b0;
        ld_mag = i_wide ? i_value : {32'd0, ld_lo};
        if (i_req_type == KIND_SDEC) begin
            if (i_wide) begin
                ld_neg = i_value[63];
                ld_mag = ld_neg ? (~i_value + 64'd1) : i_value;
            end else begin
                ld_neg = ld_lo[31];
                ld_mag = {32'd0, (ld_neg ? (~ld_lo + 32'd1) : ld_lo)};
            end
        end
        ld_chr   = (i_req_type == KIND_CHAR) || (i_req_type == KIND_PCT);
        ld_width = (i_field_width > 7'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(i_field_width);
    end

    // add 3 to every BCD digit of five or more before the shift
    always_comb begin
        logic [3:0] nib;
        for (int i = 0; i < BODY_DIGITS; i++) begin
            nib = r_digits[i*4 +: 4];
            adj[i*4 +: 4] = (nib >= 4'd5) ? (nib + 4'd3) : nib;
        end
    end

    assign body_len = r_ndig + {{(NDIG_W-1){1'b0}}, r_neg};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_req_type;
            r_upper  <= (i_req_type == KIND_HEXU);
            r_neg    <= ld_neg;
            r_left   <= i_left_align;
            r_zero   <= i_zero_pad;
            r_width  <= ld_width;
            r_bin    <= ld_mag;
            r_digits <= (i_req_type == KIND_SDEC || i_req_type == KIND_UDEC)
                        ? '0 : {{(DIGIT_BITS-64){1'b0}}, ld_mag};
            r_ndig   <= ld_chr ? NDIG_W'(1) : NDIG_W'(BODY_DIGITS);
            r_cnt    <= '0;
            r_char   <= (i_req_type == KIND_PCT) ? CHAR_PERCENT : i_value[7:0];
        end
        if (i_cmd.conv) begin
            r_digits <= {adj[DIGIT_BITS-2:0], r_bin[63]};
            r_bin    <= {r_bin[62:0], 1'b0};
            r_cnt    <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.norm || i_cmd.digit_shift) begin
            r_digits <= {r_digits[DIGIT_BITS-5:0], 4'd0};
            r_ndig   <= r_ndig - NDIG_W'(1);
        end
        if (i_cmd.prep) begin
            r_pad <= (r_width > WW'(body_len)) ? (r_width - WW'(body_len)) : '0;
        end
        if (i_cmd.pad_dec) begin
            r_pad <= r_pad - WW'(1);
        end
    end

    always_comb begin
        case (i_cmd.sel)
            SEL_PAD:   n_out_char = (r_zero && !r_left) ? CHAR_ZERO : CHAR_SPACE;
            SEL_SPACE: n_out_char = CHAR_SPACE;
            SEL_MINUS: n_out_char = CHAR_MINUS;
            SEL_DIGIT: n_out_char = itf_digit_char(r_digits[DIGIT_BITS-1 -: 4], r_upper);
            SEL_CHAR:  n_out_char = r_char;
            default:   n_out_char = CHAR_SPACE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
        r_out_char <= n_out_char;
        r_last     <= i_cmd.last;
    end

    always_comb begin
        o_sts.kind_dec  = r_kind inside {KIND_SDEC, KIND_UDEC};
        o_sts.kind_hex  = r_kind inside {KIND_HEXL, KIND_HEXU};
        o_sts.kind_chr  = r_kind inside {KIND_CHAR, KIND_PCT};
        o_sts.kind_bad  = !(o_sts.kind_dec || o_sts.kind_hex || o_sts.kind_chr);
        o_sts.conv_done = (r_cnt == CNT_W'(CONV_STEPS - 1));
        o_sts.norm_done = (r_ndig == NDIG_W'(1)) || (r_digits[DIGIT_BITS-1 -: 4] != 4'd0);
        o_sts.pad_zero  = (r_pad == '0);
        o_sts.pad_one   = (r_pad == WW'(1));
        o_sts.ndig_one  = (r_ndig == NDIG_W'(1));
        o_sts.neg       = r_neg;
        o_sts.left      = r_left;
    end

    assign o_out_char = r_out_char;
    assign o_last     = r_last;
    assign o_strobe   = r_strobe;

    `ITF_ASSERT(a_gap_after_last, (r_strobe && r_last) |=> !r_strobe, "character right after last")
    `ITF_NEVER(a_shift_empty, i_cmd.digit_shift && (r_ndig == '0), "digit emitted past body")
    `ITF_NEVER(a_pad_underflow, i_cmd.pad_dec && (r_pad == '0), "pad counter underflow")

endmodule

/* design/integer_text_formatter.sv */
// Integer text formatter: one request in, its characters out one per cycle with o_strobe.
// Decimal requests first run the 64 shift-add-3 steps; decimal and hex requests then strip
// up to 19 leading zeros; char and percent requests go straight to emission.
// Characters then follow one per cycle; busy falls as the last one shows.
// The receiver cannot stall.
// Synchronous active-low reset returns the sequencer to idle.
module integer_text_formatter #(
    parameter int MAX_WIDTH = itf_pkg::MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [63:0] i_value,
    input  logic        i_wide,
    input  logic [6:0]  i_field_width,
    input  logic        i_zero_pad,
    input  logic        i_left_align,
    output logic [7:0]  o_out_char,
    output logic        o_last,
    output logic        o_strobe
);
    import itf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    itf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    itf_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_wide        (i_wide),
        .i_field_width (i_field_width),
        .i_zero_pad    (i_zero_pad),
        .i_left_align  (i_left_align),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_char    (o_out_char),
        .o_last        (o_last),
        .o_strobe      (o_strobe)
    );

endmodule

/* test/testbench.sv */
// Self-checking bench for integer_text_formatter: random and directed conversion requests.
// Predicts each character stream in a scoreboard class; depends on itf_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import itf_pkg::*;

    localparam logic [2:0] KIND_BAD6   = 3'd6;
    localparam logic [2:0] KIND_BAD7   = 3'd7;
    localparam int         FIELD_LIMIT = MAX_WIDTH_DEF;
    localparam int         DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
        logic        wide;
        logic [6:0]  width;
        logic        zero;
        logic        left;
    } t_req;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_char;

    class format_scoreboard;
        t_out_char expected_chars[$];
        int        mismatches = 0;

        function logic [7:0] digit_char(logic [3:0] d, logic upper);
            if (d < 4'd10)
                return CHAR_ZERO + d;
            return (upper ? 8'h41 : 8'h61) + (d - 4'd10);
        endfunction

        // Works out the characters one accepted request must produce.
        function void note_request(t_req r);
            logic [7:0]  body[$];
            logic [7:0]  line[$];
            logic [63:0] mag;
            logic        neg;
            logic [7:0]  pad_ch;
            int          fw;
            t_out_char   oc;
            neg = 1'b0;
            mag = r.wide ? r.value : {32'd0, r.value[31:0]};
            case (r.kind)
                KIND_SDEC: begin
                    neg = r.wide ? r.value[63] : r.value[31];
                    if (neg)
                        mag = r.wide ? -r.value : {32'd0, -r.value[31:0]};
                    do begin
                        body.push_front(digit_char(4'(mag % 64'd10), 1'b0));
                        mag = mag / 64'd10;
                    end while (mag != 0);
                    if (neg)
                        body.push_front(CHAR_MINUS);
                end
                KIND_UDEC: begin
                    do begin
                        body.push_front(digit_char(4'(mag % 64'd10), 1'b0));
                        mag = mag / 64'd10;
                    end while (mag != 0);
                end
                KIND_HEXL, KIND_HEXU: begin
                    do begin
                        body.push_front(digit_char(mag[3:0], r.kind == KIND_HEXU));
                        mag = mag >> 4;
                    end while (mag != 0);
                end
                KIND_CHAR: body.push_back(r.value[7:0]);
                KIND_PCT:  body.push_back(CHAR_PERCENT);
                default:   return;  // unknown kind: no output at all
            endcase
            fw = (r.width > FIELD_LIMIT) ? FIELD_LIMIT : int'(r.width);
            pad_ch = (r.zero && !r.left) ? CHAR_ZERO : CHAR_SPACE;
            if (!r.left)
                for (int i = body.size(); i < fw; i++) line.push_back(pad_ch);
            foreach (body[i]) line.push_back(body[i]);
            if (r.left)
                for (int i = body.size(); i < fw; i++) line.push_back(CHAR_SPACE);
            foreach (line[i]) begin
                oc.ch   = line[i];
                oc.last = (i == line.size() - 1);
                expected_chars.push_back(oc);
            end
        endfunction

        function void check_char(logic [7:0] ch, logic last);
            t_out_char want;
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected char 0x%02h last=%0b", $realtime, ch, last);
                return;
            end
            want = expected_chars.pop_front();
            if (want.ch !== ch || want.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: char exp 0x%02h last=%0b, got 0x%02h last=%0b",
                             $realtime, want.ch, want.last, ch, last);
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic [2:0]  i_req_type    = '0;
    logic [63:0] i_value       = '0;
    logic        i_wide        = 1'b0;
    logic [6:0]  i_field_width = '0;
    logic        i_zero_pad    = 1'b0;
    logic        i_left_align  = 1'b0;
    logic        busy;
    logic [7:0]  o_out_char;
    logic        o_last;
    logic        o_strobe;

    format_scoreboard sb = new();

    integer_text_formatter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_wide        (i_wide),
        .i_field_width (i_field_width),
        .i_zero_pad    (i_zero_pad),
        .i_left_align  (i_left_align),
        .o_out_char    (o_out_char),
        .o_last        (o_last),
        .o_strobe      (o_strobe)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL integer_text_formatter");
        $finish;
    end

    // Request transfer monitor.
    always @(posedge i_clk) begin : request_mon
        t_req seen;
        if (i_rst_n && start && !busy) begin
            seen = '{i_req_type, i_value, i_wide, i_field_width, i_zero_pad, i_left_align};
            sb.note_request(seen);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_char(o_out_char, o_last);
    end

    // Holds start until the transfer happens; returns in the accepting time step.
    task automatic send_request(input logic [2:0] kind, input logic [63:0] value,
                                input logic wide, input logic [6:0] width,
                                input logic zero, input logic left);
        start         <= 1'b1;
        i_req_type    <= kind;
        i_value       <= value;
        i_wide        <= wide;
        i_field_width <= width;
        i_zero_pad    <= zero;
        i_left_align  <= left;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic maybe_idle(input int pct);
        int gap;
        if ($urandom_range(1, 100) <= pct) begin
            gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 160 : 8);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 64'($urandom_range(0, 99));
            1: return {$urandom, $urandom};
            2: return $urandom_range(0, 1) ? 64'h8000_0000_0000_0000
                                           : {$urandom, 32'h8000_0000};
            3: return $urandom_range(0, 1) ? '1 : {$urandom, 32'hFFFF_FFFF};
            4: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom_range(0, 1) ? 32'h7FFF_FFFF : $urandom};
        endcase
    endfunction

    task automatic send_random(input int idle_pct);
        logic [2:0] kind;
        logic [6:0] width;
        int         wsel;
        if ($urandom_range(0, 19) == 0)
            kind = $urandom_range(0, 1) ? KIND_BAD6 : KIND_BAD7;
        else
            kind = 3'($urandom_range(0, 5));
        wsel = $urandom_range(0, 9);
        if (wsel < 6)
            width = 7'($urandom_range(0, 24));
        else if (wsel < 9)
            width = 7'($urandom_range(25, 64));
        else
            width = 7'($urandom_range(65, 127));
        send_request(kind, pick_value(), 1'($urandom), width, 1'($urandom), 1'($urandom));
        maybe_idle(idle_pct);
    endtask

    initial begin
        int idle_pct[4] = '{0, 68, 0, 26};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every kind, padding rules and saturation.
        send_request(KIND_SDEC, 64'h8000_0000_0000_0000, 1'b1, 7'd0,   1'b0, 1'b0);
        send_request(KIND_SDEC, 64'hDEAD_BEEF_8000_0000, 1'b0, 7'd0,   1'b0, 1'b0);
        send_request(KIND_SDEC, 64'd0,                   1'b0, 7'd1,   1'b0, 1'b0);
        send_request(KIND_SDEC, 64'h0000_0000_FFFF_FFFF, 1'b0, 7'd12,  1'b1, 1'b0);
        send_request(KIND_SDEC, 64'hFFFF_FFFF_7FFF_FFFF, 1'b0, 7'd15,  1'b0, 1'b1);
        send_request(KIND_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 7'd100, 1'b1, 1'b0);
        send_request(KIND_SDEC, '1,                      1'b1, 7'd2,   1'b0, 1'b1);
        send_request(KIND_UDEC, '1,                      1'b1, 7'd0,   1'b0, 1'b0);
        send_request(KIND_UDEC, 64'h1234_5678_FFFF_FFFF, 1'b0, 7'd25,  1'b0, 1'b0);
        send_request(KIND_UDEC, 64'd0,                   1'b1, 7'd64,  1'b1, 1'b0);
        send_request(KIND_HEXL, 64'h0123_4567_89AB_CDEF, 1'b1, 7'd20,  1'b1, 1'b0);
        send_request(KIND_HEXL, 64'd0,                   1'b0, 7'd1,   1'b0, 1'b0);
        send_request(KIND_HEXU, '1,                      1'b1, 7'd0,   1'b0, 1'b0);
        send_request(KIND_HEXU, 64'hA5A5_A5A5_FEDC_BA98, 1'b0, 7'd10,  1'b1, 1'b1);
        send_request(KIND_CHAR, 64'h41,                  1'b0, 7'd5,   1'b1, 1'b0);
        send_request(KIND_CHAR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 7'd0,   1'b0, 1'b0);
        send_request(KIND_CHAR, 64'h0,                   1'b0, 7'd3,   1'b0, 1'b1);
        send_request(KIND_PCT,  {$urandom, $urandom},    1'b1, 7'd64,  1'b0, 1'b1);
        send_request(KIND_PCT,  64'd0,                   1'b0, 7'd127, 1'b1, 1'b0);
        send_request(KIND_BAD6, 64'd123,                 1'b0, 7'd8,   1'b0, 1'b0);
        send_request(KIND_BAD7, '1,                      1'b1, 7'd30,  1'b1, 1'b1);

        foreach (idle_pct[p])
            repeat (72) send_random(idle_pct[p]);
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS integer_text_formatter");
        else
            $display("FAIL integer_text_formatter");
        $finish;
    end
endmodule

/* integer_text_formatter.f */
+incdir+design
design/itf_pkg.sv
design/itf_ctrl.sv
design/itf_dp.sv
design/integer_text_formatter.sv
test/testbench.sv
